// ===== rtl/core/array_list_engine_assert.svh =====
// Assertion macros for the top level of the list engine.
// Each macro checks an implication on the rising clock edge and is
// switched off while reset is asserted.
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array_list_engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ALE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array_list_engine: next-cycle check failed");

`endif

// ===== rtl/core/ale_pkg.sv =====
`default_nettype none

package ale_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VALUE_W   = 32;
    localparam int FIELD_W   = 6;

    typedef enum logic [2:0] {
        OP_APPEND       = 3'd0,
        OP_PREPEND      = 3'd1,
        OP_REMOVE_LAST  = 3'd2,
        OP_REMOVE_FIRST = 3'd3,
        OP_SWAP         = 3'd4,
        OP_REVERSE      = 3'd5,
        OP_CLEAR        = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_EMPTY  = 2'd2,
        STATUS_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B,
        S_LIST
    } state_t;

    // Source of the data written into the element store.
    typedef enum logic [1:0] {
        WSEL_VALUE,
        WSEL_RDATA,
        WSEL_TMP
    } wsel_t;

    typedef struct packed {
        logic [2:0]                operation;
        logic signed [VALUE_W-1:0] value;
        logic [FIELD_W-1:0]        first_position;
        logic [FIELD_W-1:0]        second_position;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] element;
        logic [FIELD_W-1:0]        element_position;
        logic                      element_valid;
        logic [FIELD_W-1:0]        count;
        logic                      last;
    } result_t;

    // Control from the sequencer to the datapath for the current cycle.
    typedef struct packed {
        logic               wr_en;
        wsel_t              wsel;
        logic               tmp_ld;
        logic               emit;
        logic               elem;
        status_t            status;
        logic [FIELD_W-1:0] pos;
        logic [FIELD_W-1:0] count;
        logic               last;
    } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ale_ram.sv =====
`default_nettype none

module ale_ram #(
    parameter int WIDTH = ale_pkg::VALUE_W,
    parameter int DEPTH = ale_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ale_addr.sv =====
`default_nettype none

// Maps a logical list index onto a store address around the ring head.
module ale_addr #(
    parameter int DEPTH = ale_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic [AW-1:0] head,
    input  wire logic [AW-1:0] laddr,
    output logic      [AW-1:0] phys
);

    localparam int AW1 = AW + 1;

    logic [AW1-1:0] sum;

    always_comb
    begin
        sum = AW1'(head) + AW1'(laddr);
        if (sum >= AW1'(DEPTH))
        begin
            sum = sum - AW1'(DEPTH);
        end
        phys = sum[AW-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ale_seq.sv =====
`default_nettype none

module ale_seq #(
    parameter int DEPTH = ale_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [2:0]                     operation,
    input  wire logic [ale_pkg::FIELD_W-1:0]    first_position,
    input  wire logic [ale_pkg::FIELD_W-1:0]    second_position,
    input  wire logic [AW-1:0]                  phys,
    output logic                                busy,
    output logic [AW-1:0]                       laddr,
    output logic [AW-1:0]                       head,
    output ale_pkg::ctrl_t                      ctrl
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int AW1 = AW + 1;
    localparam int FW  = ale_pkg::FIELD_W;
    localparam int PW  = (CW > FW) ? CW : FW;

    ale_pkg::state_t state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    logic [FW-1:0]   p1_reg, p1_next;
    logic [FW-1:0]   p2_reg, p2_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   a_reg, a_next;
    logic [AW-1:0]   b_reg, b_next;

    logic              count_full;
    logic              count_empty;
    logic              p1_bad;
    logic              p2_bad;
    logic              err;
    ale_pkg::status_t  err_status;
    logic              idx_last;
    logic              rev_more;
    logic              rev_go;
    logic              is_rev;

    assign count_full  = (count_reg == CW'(DEPTH));
    assign count_empty = (count_reg == '0);
    assign p1_bad      = (p1_reg == '0) || (PW'(p1_reg) > PW'(count_reg));
    assign p2_bad      = (p2_reg == '0) || (PW'(p2_reg) > PW'(count_reg));
    assign idx_last    = ((AW1'(idx_reg) + AW1'(1)) == AW1'(count_reg));
    assign rev_more    = ((AW1'(a_reg) + AW1'(2)) < AW1'(b_reg));
    assign rev_go      = (count_reg >= CW'(2));
    assign is_rev      = (op_reg == ale_pkg::OP_REVERSE);
    assign busy        = (state_reg != ale_pkg::S_IDLE);
    assign head        = head_reg;

    always_comb
    begin
        err        = 1'b0;
        err_status = ale_pkg::STATUS_OK;
        case (op_reg)
            ale_pkg::OP_APPEND, ale_pkg::OP_PREPEND:
            begin
                err        = count_full;
                err_status = ale_pkg::STATUS_FULL;
            end
            ale_pkg::OP_REMOVE_LAST, ale_pkg::OP_REMOVE_FIRST:
            begin
                err        = count_empty;
                err_status = ale_pkg::STATUS_EMPTY;
            end
            ale_pkg::OP_SWAP:
            begin
                err        = p1_bad || p2_bad;
                err_status = ale_pkg::STATUS_BADPOS;
            end
            default:
            begin
                err = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ale_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ale_pkg::S_EXEC;
                end
            end
            ale_pkg::S_EXEC:
            begin
                if (err)
                begin
                    state_next = ale_pkg::S_IDLE;
                end
                else if ((op_reg == ale_pkg::OP_SWAP) || (is_rev && rev_go))
                begin
                    state_next = ale_pkg::S_RD_A;
                end
                else
                begin
                    state_next = ale_pkg::S_LIST;
                end
            end
            ale_pkg::S_RD_A: state_next = ale_pkg::S_RD_B;
            ale_pkg::S_RD_B: state_next = ale_pkg::S_WR_A;
            ale_pkg::S_WR_A: state_next = ale_pkg::S_WR_B;
            ale_pkg::S_WR_B:
            begin
                state_next = (is_rev && rev_more) ? ale_pkg::S_RD_A : ale_pkg::S_LIST;
            end
            ale_pkg::S_LIST:
            begin
                if (count_empty || idx_last)
                begin
                    state_next = ale_pkg::S_IDLE;
                end
            end
            default: state_next = ale_pkg::S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        ctrl        = '0;
        ctrl.wsel   = ale_pkg::WSEL_VALUE;
        ctrl.status = ale_pkg::STATUS_OK;
        ctrl.count  = FW'(count_reg);
        laddr       = idx_reg;
        case (state_reg)
            ale_pkg::S_EXEC:
            begin
                if (err)
                begin
                    ctrl.emit   = 1'b1;
                    ctrl.status = err_status;
                    ctrl.last   = 1'b1;
                end
                else
                begin
                    case (op_reg)
                        ale_pkg::OP_APPEND:
                        begin
                            laddr      = AW'(count_reg);
                            ctrl.wr_en = 1'b1;
                        end
                        ale_pkg::OP_PREPEND:
                        begin
                            laddr      = AW'(DEPTH - 1);
                            ctrl.wr_en = 1'b1;
                        end
                        ale_pkg::OP_REMOVE_FIRST:
                        begin
                            laddr = AW'(1);
                        end
                        default:
                        begin
                            laddr = idx_reg;
                        end
                    endcase
                end
            end
            ale_pkg::S_RD_A:
            begin
                laddr = a_reg;
            end
            ale_pkg::S_RD_B:
            begin
                laddr       = b_reg;
                ctrl.tmp_ld = 1'b1;
            end
            ale_pkg::S_WR_A:
            begin
                laddr      = a_reg;
                ctrl.wr_en = 1'b1;
                ctrl.wsel  = ale_pkg::WSEL_RDATA;
            end
            ale_pkg::S_WR_B:
            begin
                laddr      = b_reg;
                ctrl.wr_en = 1'b1;
                ctrl.wsel  = ale_pkg::WSEL_TMP;
            end
            ale_pkg::S_LIST:
            begin
                ctrl.emit = 1'b1;
                if (count_empty)
                begin
                    ctrl.last = 1'b1;
                end
                else
                begin
                    laddr     = idx_reg;
                    ctrl.elem = 1'b1;
                    ctrl.pos  = FW'(AW1'(idx_reg) + AW1'(1));
                    ctrl.last = idx_last;
                end
            end
            default:
            begin
                laddr = idx_reg;
            end
        endcase
    end

    // Command, list bookkeeping and loop indexes.
    always_comb
    begin
        op_next    = op_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        count_next = count_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        case (state_reg)
            ale_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = operation;
                    p1_next  = first_position;
                    p2_next  = second_position;
                    idx_next = '0;
                end
            end
            ale_pkg::S_EXEC:
            begin
                if (!err)
                begin
                    case (op_reg)
                        ale_pkg::OP_APPEND:
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        ale_pkg::OP_PREPEND:
                        begin
                            head_next  = phys;
                            count_next = count_reg + CW'(1);
                        end
                        ale_pkg::OP_REMOVE_LAST:
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        ale_pkg::OP_REMOVE_FIRST:
                        begin
                            head_next  = phys;
                            count_next = count_reg - CW'(1);
                        end
                        ale_pkg::OP_SWAP:
                        begin
                            a_next = AW'(p1_reg - FW'(1));
                            b_next = AW'(p2_reg - FW'(1));
                        end
                        ale_pkg::OP_REVERSE:
                        begin
                            a_next = '0;
                            b_next = AW'(count_reg - CW'(1));
                        end
                        ale_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            head_next  = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ale_pkg::S_WR_B:
            begin
                a_next = a_reg + AW'(1);
                b_next = b_reg - AW'(1);
            end
            ale_pkg::S_LIST:
            begin
                idx_next = idx_reg + AW'(1);
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ale_pkg::S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        idx_reg <= idx_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/array_list_engine.sv =====
`default_nettype none

`include "array_list_engine_assert.svh"

// Ordered list of up to DEPTH signed 32-bit values kept in a ring buffer,
// so append, prepend and both removals only move a head pointer and a
// count, while swap and reverse exchange entries through the store, whose
// read and write share one address. A command is taken at a clock edge
// where start is high and busy is low, and busy stays high until the
// sequencer has issued its last result. One shared modular address adder
// serves every store access, one access per cycle. An item runs an
// execute state, then reads A, reads B, writes A and writes B for each
// swapped pair (one pair for swap, floor(count/2) pairs for reverse),
// then lists the elements in order (a single result when the list ends
// up empty). Results pass through a pending register and an output
// register behind the sequencer, one per cycle, each shown for exactly one
// cycle with result_valid high; the receiver cannot stall them, so it must
// take every result in the cycle it appears. A rejected command gives one
// result with an error status and last set. No clearing pass is needed
// after reset, since only entries below the count are ever used.
module array_list_engine #(
    parameter int DEPTH = ale_pkg::DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire ale_pkg::cmd_t    cmd,
    output logic                  busy,
    output ale_pkg::result_t      result,
    output logic                  result_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW = ale_pkg::VALUE_W;

    logic              accept;
    logic [AW-1:0]     laddr;
    logic [AW-1:0]     head;
    logic [AW-1:0]     phys;
    ale_pkg::ctrl_t    ctrl;
    logic [VW-1:0]     wdata;
    logic [VW-1:0]     rdata;

    // Value of the command in progress, and the first entry of a pair
    // being exchanged.
    logic [VW-1:0]     value_reg;
    logic [VW-1:0]     tmp_reg;

    // A result whose store read is in flight, then the result on the ports.
    logic              pend_valid_reg;
    ale_pkg::ctrl_t    pend_reg;
    logic              result_valid_reg;
    ale_pkg::result_t  result_reg;
    ale_pkg::result_t  result_next;

    // A result on the ports that carries an error status.
    logic              result_err;

    assign accept = start && !busy;

    ale_seq #(
        .DEPTH(DEPTH)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .operation      (cmd.operation),
        .first_position (cmd.first_position),
        .second_position(cmd.second_position),
        .phys           (phys),
        .busy           (busy),
        .laddr          (laddr),
        .head           (head),
        .ctrl           (ctrl)
    );

    // The one address unit: every read and write goes through it.
    ale_addr #(
        .DEPTH(DEPTH)
    ) u_addr (
        .head (head),
        .laddr(laddr),
        .phys (phys)
    );

    ale_ram #(
        .WIDTH(VW),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .wr_en(ctrl.wr_en),
        .waddr(phys),
        .wdata(wdata),
        .raddr(phys),
        .rdata(rdata)
    );

    // During an exchange the first entry is written straight from the store
    // read of the second, and the second entry from the saved copy of the first.
    always_comb
    begin
        case (ctrl.wsel)
            ale_pkg::WSEL_RDATA: wdata = rdata;
            ale_pkg::WSEL_TMP:   wdata = tmp_reg;
            default:             wdata = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= cmd.value;
        end
        if (ctrl.tmp_ld)
        begin
            tmp_reg <= rdata;
        end
        pend_reg   <= ctrl;
        result_reg <= result_next;
    end

    // The store data for a listed element arrives in the cycle after the
    // sequencer issues it, which is when the pending result is completed.
    always_comb
    begin
        result_next.status           = pend_reg.status;
        result_next.element          = pend_reg.elem ? rdata : '0;
        result_next.element_position = pend_reg.elem ? pend_reg.pos : '0;
        result_next.element_valid    = pend_reg.elem;
        result_next.count            = pend_reg.count;
        result_next.last             = pend_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg   <= ctrl.emit;
            result_valid_reg <= pend_valid_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;
    assign result_err   = result_valid && (result.status != ale_pkg::STATUS_OK);

    // A command once taken keeps the block busy for at least its execute cycle.
    `ALE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, busy)
    // A result without an element is always the only and final one.
    `ALE_ASSERT_SAME(a_empty_is_last, clk, rst_n, result_valid && !result.element_valid, result.last)
    // A rejected command never carries an element.
    `ALE_ASSERT_SAME(a_error_no_element, clk, rst_n, result_err, !result.element_valid && result.last)

endmodule

`default_nettype wire
